// ===== src/assert_macros.svh =====
// Assertion macros for the vertex transform block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VTP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VTP_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define VTP_ASSERT(label, clk, rst_n, prop, msg)
`define VTP_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== src/vtp_pkg.sv =====
// Shared constants and types for the vertex transform block
package vtp_pkg;
    localparam int FRAC_BITS = 8;
    localparam int COORD_W   = 16;
    localparam int ELEM_W    = 16;
    localparam int ROW_W     = 48;
    localparam int DIST_W    = 16;
    localparam int WORLD_W   = 32;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 34;
    localparam int NUM_W     = 49;
    localparam int QMAG_W    = 48;
    localparam int DEN_W     = 32;
    localparam int IDX_W     = 3;

    localparam logic [IDX_W-1:0] REG_ROW_X    = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW_Y    = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW_Z    = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW_SHIFT = 3'd3;
    localparam logic [IDX_W-1:0] REG_DISTANCE = 3'd4;

    typedef struct packed {
        logic valid;
        logic last;
    } pipe_ctl_t;

    typedef struct packed {
        logic                        valid;
        logic                        last;
        logic                        neg_x;
        logic                        neg_y;
        logic                        zero;
        logic signed [WORLD_W-1:0]   wx;
        logic signed [WORLD_W-1:0]   wy;
        logic signed [WORLD_W-1:0]   wz;
    } div_side_t;

    function automatic logic signed [ELEM_W-1:0] elem(input logic [ROW_W-1:0] row,
                                                     input int unsigned col);
        return row[col*ELEM_W +: ELEM_W];
    endfunction
endpackage

// ===== src/vtp_transform.sv =====
// Matrix multiply and translation: products stage, then sum and truncate stage
module vtp_transform (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  vtp_pkg::pipe_ctl_t                    ctl_in,
    input  logic signed [vtp_pkg::COORD_W-1:0]    lx,
    input  logic signed [vtp_pkg::COORD_W-1:0]    ly,
    input  logic signed [vtp_pkg::COORD_W-1:0]    lz,
    input  logic [vtp_pkg::ROW_W-1:0]             row_x,
    input  logic [vtp_pkg::ROW_W-1:0]             row_y,
    input  logic [vtp_pkg::ROW_W-1:0]             row_z,
    input  logic [vtp_pkg::ROW_W-1:0]             row_shift,
    output vtp_pkg::pipe_ctl_t                    ctl_out,
    output logic signed [vtp_pkg::WORLD_W-1:0]    wx,
    output logic signed [vtp_pkg::WORLD_W-1:0]    wy,
    output logic signed [vtp_pkg::WORLD_W-1:0]    wz
);
    vtp_pkg::pipe_ctl_t ctl1_reg, ctl2_reg;
    logic signed [vtp_pkg::PROD_W-1:0] prod_reg [3][3];
    logic signed [vtp_pkg::ELEM_W-1:0] off_reg [3];
    logic signed [vtp_pkg::WORLD_W-1:0] world_reg [3];
    logic signed [vtp_pkg::WORLD_W-1:0] world_next [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else if (en) begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                prod_reg[0][c]  <= vtp_pkg::PROD_W'(lx)
                                 * vtp_pkg::PROD_W'(vtp_pkg::elem(row_x, c));
                prod_reg[1][c]  <= vtp_pkg::PROD_W'(ly)
                                 * vtp_pkg::PROD_W'(vtp_pkg::elem(row_y, c));
                prod_reg[2][c]  <= vtp_pkg::PROD_W'(lz)
                                 * vtp_pkg::PROD_W'(vtp_pkg::elem(row_z, c));
                off_reg[c]      <= vtp_pkg::elem(row_shift, c);
                world_reg[c]    <= world_next[c];
            end
        end
    end

    // Truncate toward zero: bias negative sums before the arithmetic shift.
    // The sum stays far inside 32 bits after scaling, so no clamp is needed.
    always_comb begin
        logic signed [vtp_pkg::ACC_W-1:0] acc;
        logic signed [vtp_pkg::ACC_W-1:0] shifted;
        for (int c = 0; c < 3; c++) begin
            acc = vtp_pkg::ACC_W'(prod_reg[0][c]) + vtp_pkg::ACC_W'(prod_reg[1][c])
                + vtp_pkg::ACC_W'(prod_reg[2][c]) + vtp_pkg::ACC_W'(off_reg[c]);
            if (acc[vtp_pkg::ACC_W-1])
                acc = acc + vtp_pkg::ACC_W'((1 << vtp_pkg::FRAC_BITS) - 1);
            shifted = acc >>> vtp_pkg::FRAC_BITS;
            world_next[c] = shifted[vtp_pkg::WORLD_W-1:0];
        end
    end

    assign ctl_out = ctl2_reg;
    assign wx = world_reg[0];
    assign wy = world_reg[1];
    assign wz = world_reg[2];
endmodule

// ===== src/vtp_prep.sv =====
// Projection set-up: distance products, then magnitudes and signs for the divider
module vtp_prep (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  vtp_pkg::pipe_ctl_t                    ctl_in,
    input  logic signed [vtp_pkg::WORLD_W-1:0]    wx,
    input  logic signed [vtp_pkg::WORLD_W-1:0]    wy,
    input  logic signed [vtp_pkg::WORLD_W-1:0]    wz,
    input  logic [vtp_pkg::DIST_W-1:0]            view_dist,
    output vtp_pkg::div_side_t                    side_out,
    output logic [vtp_pkg::QMAG_W-1:0]            num_x,
    output logic [vtp_pkg::QMAG_W-1:0]            num_y,
    output logic [vtp_pkg::DEN_W-1:0]             den
);
    vtp_pkg::pipe_ctl_t ctl_reg;
    logic signed [vtp_pkg::NUM_W-1:0]   px_reg, py_reg;
    logic signed [vtp_pkg::WORLD_W-1:0] wx_reg, wy_reg, wz_reg;
    vtp_pkg::div_side_t side_reg;
    logic [vtp_pkg::QMAG_W-1:0] nx_reg, ny_reg;
    logic [vtp_pkg::DEN_W-1:0]  den_reg;
    logic signed [vtp_pkg::DIST_W:0] dist_s;
    logic [vtp_pkg::NUM_W-1:0] ax, ay;
    logic [vtp_pkg::WORLD_W-1:0] az;

    assign dist_s = {1'b0, view_dist};
    assign ax = px_reg[vtp_pkg::NUM_W-1] ? vtp_pkg::NUM_W'(-px_reg) : px_reg;
    assign ay = py_reg[vtp_pkg::NUM_W-1] ? vtp_pkg::NUM_W'(-py_reg) : py_reg;
    assign az = wz_reg[vtp_pkg::WORLD_W-1] ? vtp_pkg::WORLD_W'(-wz_reg) : wz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg        <= '0;
            side_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg        <= ctl_in;
            side_reg.valid <= ctl_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg  <= vtp_pkg::NUM_W'(dist_s) * vtp_pkg::NUM_W'(wx);
            py_reg  <= vtp_pkg::NUM_W'(dist_s) * vtp_pkg::NUM_W'(wy);
            wx_reg  <= wx;
            wy_reg  <= wy;
            wz_reg  <= wz;
            side_reg.last  <= ctl_reg.last;
            side_reg.neg_x <= px_reg[vtp_pkg::NUM_W-1] ^ wz_reg[vtp_pkg::WORLD_W-1];
            side_reg.neg_y <= py_reg[vtp_pkg::NUM_W-1] ^ wz_reg[vtp_pkg::WORLD_W-1];
            side_reg.zero  <= (wz_reg == '0);
            side_reg.wx    <= wx_reg;
            side_reg.wy    <= wy_reg;
            side_reg.wz    <= wz_reg;
            nx_reg  <= ax[vtp_pkg::QMAG_W-1:0];
            ny_reg  <= ay[vtp_pkg::QMAG_W-1:0];
            den_reg <= az;
        end
    end

    assign side_out = side_reg;
    assign num_x = nx_reg;
    assign num_y = ny_reg;
    assign den   = den_reg;
endmodule

// ===== src/vtp_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage for x and y
module vtp_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  vtp_pkg::div_side_t              side_in,
    input  logic [vtp_pkg::QMAG_W-1:0]      num_x,
    input  logic [vtp_pkg::QMAG_W-1:0]      num_y,
    input  logic [vtp_pkg::DEN_W-1:0]       den,
    output vtp_pkg::div_side_t              side_out,
    output logic [vtp_pkg::QMAG_W-1:0]      quo_x,
    output logic [vtp_pkg::QMAG_W-1:0]      quo_y
);
    localparam int N = vtp_pkg::QMAG_W;

    vtp_pkg::div_side_t              side_reg [N+1];
    logic [vtp_pkg::DEN_W-1:0]       den_reg  [N+1];
    logic [vtp_pkg::DEN_W-1:0]       rx_reg   [N+1];
    logic [vtp_pkg::DEN_W-1:0]       ry_reg   [N+1];
    logic [N-1:0]                    qx_reg   [N+1];
    logic [N-1:0]                    qy_reg   [N+1];

    // Stage 0 is the divider's input; it is fed straight from the set-up stage.
    always_comb begin
        side_reg[0] = side_in;
        den_reg[0]  = den;
        rx_reg[0]   = '0;
        ry_reg[0]   = '0;
        qx_reg[0]   = num_x;
        qy_reg[0]   = num_y;
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [vtp_pkg::DEN_W:0] tx, ty, dx, dy;
        assign tx = {rx_reg[i], qx_reg[i][N-1]};
        assign ty = {ry_reg[i], qy_reg[i][N-1]};
        assign dx = tx - {1'b0, den_reg[i]};
        assign dy = ty - {1'b0, den_reg[i]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[i+1].valid <= 1'b0;
            end else if (en) begin
                side_reg[i+1].valid <= side_reg[i].valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i+1].last  <= side_reg[i].last;
                side_reg[i+1].neg_x <= side_reg[i].neg_x;
                side_reg[i+1].neg_y <= side_reg[i].neg_y;
                side_reg[i+1].zero  <= side_reg[i].zero;
                side_reg[i+1].wx    <= side_reg[i].wx;
                side_reg[i+1].wy    <= side_reg[i].wy;
                side_reg[i+1].wz    <= side_reg[i].wz;
                den_reg[i+1] <= den_reg[i];
                // Keep the remainder below the divisor; shift quotient bits in at the bottom.
                rx_reg[i+1]  <= dx[vtp_pkg::DEN_W] ? tx[vtp_pkg::DEN_W-1:0]
                                                   : dx[vtp_pkg::DEN_W-1:0];
                ry_reg[i+1]  <= dy[vtp_pkg::DEN_W] ? ty[vtp_pkg::DEN_W-1:0]
                                                   : dy[vtp_pkg::DEN_W-1:0];
                qx_reg[i+1]  <= {qx_reg[i][N-2:0], ~dx[vtp_pkg::DEN_W]};
                qy_reg[i+1]  <= {qy_reg[i][N-2:0], ~dy[vtp_pkg::DEN_W]};
            end
        end
    end

    assign side_out = side_reg[N];
    assign quo_x    = qx_reg[N];
    assign quo_y    = qy_reg[N];
endmodule

// ===== src/vertex_transform_project.sv =====
// Top level: affine vertex transform with perspective projection
//
//  Channel | Ports                              | Carries
//  --------+------------------------------------+------------------------------------
//  in      | s_tvalid s_tready s_tdata s_tlast  | one vertex per item
//  out     | m_tvalid m_tready m_tdata m_tlast  | world and screen coordinates
//  config  | cfg_valid cfg_ready cfg_index      | one register write per handshake
//          | cfg_data                           |
//
// One item per cycle while the skid register is empty. From input to output register:
// two transform stages, two projection set-up stages, 48 divider stages (one
// quotient bit each, which sets the depth) and the output register.
// Reset (synchronous, active low) clears all valid bits and loads the identity
// matrix, zero translation and a distance of 256.
// A stall at the output freezes the whole pipeline only once the skid register
// is full; the input keeps taking an item while a result waits to be taken.
module vertex_transform_project (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [47:0]                       s_tdata,   // local_x, local_y, local_z
    input  logic                              s_tlast,   // last_vertex
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [159:0]                      m_tdata,   // world_x, world_y, world_z,
                                                         // screen_x, screen_y
    output logic                              m_tlast,   // last_out
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vtp_pkg::IDX_W-1:0]         cfg_index,
    input  logic [vtp_pkg::ROW_W-1:0]         cfg_data
);
    logic [vtp_pkg::ROW_W-1:0]  row_x_reg, row_y_reg, row_z_reg, row_shift_reg;
    logic [vtp_pkg::DIST_W-1:0] dist_reg;

    // Configuration: always ready; unknown indices are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_x_reg     <= vtp_pkg::ROW_W'(256);
            row_y_reg     <= vtp_pkg::ROW_W'(256) << 16;
            row_z_reg     <= vtp_pkg::ROW_W'(256) << 32;
            row_shift_reg <= '0;
            dist_reg      <= vtp_pkg::DIST_W'(256);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                vtp_pkg::REG_ROW_X:     row_x_reg     <= cfg_data;
                vtp_pkg::REG_ROW_Y:     row_y_reg     <= cfg_data;
                vtp_pkg::REG_ROW_Z:     row_z_reg     <= cfg_data;
                vtp_pkg::REG_ROW_SHIFT: row_shift_reg <= cfg_data;
                vtp_pkg::REG_DISTANCE:  dist_reg      <= cfg_data[vtp_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances whenever the skid register is empty.
    logic skid_v_reg;
    logic en;
    assign en       = !skid_v_reg;
    assign s_tready = en;

    vtp_pkg::pipe_ctl_t ctl_in, ctl_t;
    logic signed [vtp_pkg::WORLD_W-1:0] wx, wy, wz;

    assign ctl_in.valid = s_tvalid;
    assign ctl_in.last  = s_tlast;

    vtp_transform u_transform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .ctl_in    (ctl_in),
        .lx        (s_tdata[15:0]),
        .ly        (s_tdata[31:16]),
        .lz        (s_tdata[47:32]),
        .row_x     (row_x_reg),
        .row_y     (row_y_reg),
        .row_z     (row_z_reg),
        .row_shift (row_shift_reg),
        .ctl_out   (ctl_t),
        .wx        (wx),
        .wy        (wy),
        .wz        (wz)
    );

    vtp_pkg::div_side_t side_p, side_d;
    logic [vtp_pkg::QMAG_W-1:0] num_x, num_y, quo_x, quo_y;
    logic [vtp_pkg::DEN_W-1:0]  den;

    vtp_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .ctl_in    (ctl_t),
        .wx        (wx),
        .wy        (wy),
        .wz        (wz),
        .view_dist (dist_reg),
        .side_out  (side_p),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (den)
    );

    vtp_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .side_in  (side_p),
        .num_x    (num_x),
        .num_y    (num_y),
        .den      (den),
        .side_out (side_d),
        .quo_x    (quo_x),
        .quo_y    (quo_y)
    );

    // Apply the quotient sign and clamp to 32 bits; zero depth gives zero.
    function automatic logic [31:0] finish(input logic [vtp_pkg::QMAG_W-1:0] q,
                                           input logic neg, input logic zero);
        logic [vtp_pkg::QMAG_W-1:0] neg_q;
        logic [31:0] r;
        neg_q = -q;
        if (zero)
            r = '0;
        else if (!neg)
            r = (q > vtp_pkg::QMAG_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : q[31:0];
        else
            r = (q > vtp_pkg::QMAG_W'(32'h8000_0000)) ? 32'h8000_0000 : neg_q[31:0];
        return r;
    endfunction

    logic [159:0] fin_data;
    assign fin_data = {finish(quo_y, side_d.neg_y, side_d.zero),
                       finish(quo_x, side_d.neg_x, side_d.zero),
                       side_d.wz, side_d.wy, side_d.wx};

    logic         m_v_reg, m_last_reg, skid_last_reg;
    logic [159:0] m_data_reg, skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg    <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (m_tready || !m_v_reg) begin
            // Output free: refill from skid first, else from the pipeline.
            m_v_reg    <= skid_v_reg || side_d.valid;
            skid_v_reg <= 1'b0;
        end else if (en && side_d.valid) begin
            // Output held: park the result leaving the pipeline.
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !m_v_reg) begin
            m_data_reg <= skid_v_reg ? skid_data_reg : fin_data;
            m_last_reg <= skid_v_reg ? skid_last_reg : side_d.last;
        end
        if (en) begin
            skid_data_reg <= fin_data;
            skid_last_reg <= side_d.last;
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`include "assert_macros.svh"
    `VTP_ASSERT(a_skid_implies_out, aclk, aresetn, skid_v_reg |-> m_v_reg, "skid full while output empty")
    `VTP_ASSERT(a_skid_on_stall, aclk, aresetn, $rose(skid_v_reg) |-> $past(m_v_reg && !m_tready), "skid filled without stall")
    `VTP_ASSERT(a_zero_depth, aclk, aresetn, (m_v_reg && m_data_reg[95:64] == 32'd0) |-> (m_data_reg[159:96] == 64'd0), "zero depth gave nonzero screen")
endmodule
